// ----- design/tcce_pkg.sv -----
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared codes, widths and the result type of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int CellW = 16;
  localparam int ColW  = 7;
  localparam int RowW  = 5;
  localparam int OffW  = 11;
  localparam int ByteW = 8;
  localparam int ModeW = 3;

  localparam logic [ModeW-1:0] MODE_PUT = 3'd0;
  localparam logic [ModeW-1:0] MODE_CLS = 3'd1;
  localparam logic [ModeW-1:0] MODE_CLL = 3'd2;
  localparam logic [ModeW-1:0] MODE_SET = 3'd3;
  localparam logic [ModeW-1:0] MODE_RD  = 3'd4;

  localparam logic [ByteW-1:0] CH_BS  = 8'd8;
  localparam logic [ByteW-1:0] CH_TAB = 8'd9;
  localparam logic [ByteW-1:0] CH_LF  = 8'd10;
  localparam logic [ByteW-1:0] CH_CR  = 8'd13;

  localparam logic [ByteW-1:0] TEXT_COLOR_RST = 8'h07;

  typedef struct packed {
    logic             vld;
    logic [ColW-1:0]  col;
    logic [RowW-1:0]  row;
    logic [OffW-1:0]  offset;
    logic [ByteW-1:0] char_code;
    logic [ByteW-1:0] attr;
  } tcce_res_t;

endpackage

// ----- design/tcce_ram.sv -----
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tcce_core.sv -----
// ----------------------------------------------------------------------------
// tcce_core
// Cursor state and sequencer driving the cell store: init, put, set, scroll, clear, read.
// ----------------------------------------------------------------------------
module tcce_core import tcce_pkg::*; #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ModeW-1:0]                    mode_i,
  input  logic [ByteW-1:0]                    char_code_i,
  input  logic [RowW-1:0]                     row_i,
  input  logic [ColW-1:0]                     column_i,
  input  logic [ByteW-1:0]                    text_color_i,
  input  logic                                out_free_i,
  output tcce_res_t                           res_o,
  output logic                                ram_we_o,
  output logic [$clog2(COLS*ROWS)-1:0]        ram_waddr_o,
  output logic [CellW-1:0]                    ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(COLS*ROWS)-1:0]        ram_raddr_o,
  input  logic [CellW-1:0]                    ram_rdata_i
);

  localparam int NCell = COLS * ROWS;
  localparam int NMove = COLS * (ROWS - 1);
  localparam int AW    = $clog2(NCell);
  localparam int RW    = $clog2(ROWS + 1);
  localparam int NStop = (COLS + TAB_STOP - 1) / TAB_STOP;

  typedef enum logic [6:0] {
    S_INIT   = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_SCROLL = 7'b0001000,
    S_CLEAR  = 7'b0010000,
    S_RDATA  = 7'b0100000,
    S_HOLD   = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [ModeW-1:0] mode_q, mode_d;
  logic [ByteW-1:0] char_q, char_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [ColW-1:0]  cur_col_q, cur_col_d;
  logic [RW-1:0]    cur_row_q, cur_row_d;
  logic [AW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    clr_last_q, clr_last_d;
  logic             rd_pend_q, rd_pend_d;
  logic [ByteW-1:0] hold_char_q, hold_char_d;
  logic [ByteW-1:0] hold_attr_q, hold_attr_d;

  logic [ByteW-1:0] fin_char, fin_attr;
  logic             go_fin;
  logic [ByteW-1:0] tab_stop;
  logic [ColW:0]    col_inc;
  logic [AW-1:0]    cur_addr, cell_addr;
  logic             row_ok, col_ok;

  // next tab stop above the cursor column
  always_comb begin
    tab_stop = 8'(NStop * TAB_STOP);
    for (int k = NStop; k >= 1; k--) begin
      if (k * TAB_STOP > int'(cur_col_q)) begin
        tab_stop = 8'(k * TAB_STOP);
      end
    end
  end

  assign col_inc   = {1'b0, cur_col_q} + 1'b1;
  assign cur_addr  = AW'(int'(cur_row_q) * COLS + int'(cur_col_q));
  assign cell_addr = AW'(int'(row_q) * COLS + int'(col_q));
  assign row_ok    = int'(row_q) < ROWS;
  assign col_ok    = int'(col_q) < COLS;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    char_d      = char_q;
    row_d       = row_q;
    col_d       = col_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    cnt_d       = cnt_q;
    clr_last_d  = clr_last_q;
    rd_pend_d   = rd_pend_q;
    hold_char_d = hold_char_q;
    hold_attr_d = hold_attr_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = cnt_q;
    ram_wdata_o = {text_color_i, 8'h00};
    ram_re_o    = 1'b0;
    ram_raddr_o = cell_addr;
    fin_char    = '0;
    fin_attr    = '0;
    go_fin      = 1'b0;

    case (state_q)
      S_INIT: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        if (cnt_q == AW'(NCell - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          char_d  = char_code_i;
          row_d   = row_i;
          col_d   = column_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        case (mode_q)
          MODE_PUT: begin
            if (int'(cur_row_q) >= ROWS) begin
              // scroll pending
              cur_row_d = cur_row_q - 1'b1;
              cnt_d     = '0;
              rd_pend_d = 1'b0;
              state_d   = S_SCROLL;
            end else begin
              go_fin = 1'b1;
              case (char_q)
                CH_LF: begin
                  cur_col_d = '0;
                  cur_row_d = cur_row_q + 1'b1;
                end
                CH_CR: begin
                  cur_col_d = '0;
                end
                CH_BS: begin
                  if (cur_col_q != '0) begin
                    cur_col_d = cur_col_q - 1'b1;
                  end
                end
                CH_TAB: begin
                  if (int'(tab_stop) >= COLS) begin
                    cur_col_d = '0;
                    cur_row_d = cur_row_q + 1'b1;
                  end else begin
                    cur_col_d = tab_stop[ColW-1:0];
                  end
                end
                default: begin
                  ram_we_o    = 1'b1;
                  ram_waddr_o = cur_addr;
                  ram_wdata_o = {text_color_i, char_q};
                  if (int'(col_inc) >= COLS) begin
                    cur_col_d = '0;
                    cur_row_d = cur_row_q + 1'b1;
                  end else begin
                    cur_col_d = col_inc[ColW-1:0];
                  end
                end
              endcase
            end
          end
          MODE_CLS: begin
            cur_col_d  = '0;
            cur_row_d  = '0;
            cnt_d      = '0;
            clr_last_d = AW'(NCell - 1);
            state_d    = S_CLEAR;
          end
          MODE_CLL: begin
            if (row_ok) begin
              if (int'(row_q) == int'(cur_row_q)) begin
                cur_col_d = '0;
              end
              cnt_d      = AW'(int'(row_q) * COLS);
              clr_last_d = AW'(int'(row_q) * COLS + COLS - 1);
              state_d    = S_CLEAR;
            end else begin
              go_fin = 1'b1;
            end
          end
          MODE_SET: begin
            cur_row_d = row_ok ? RW'(row_q) : RW'(ROWS - 1);
            cur_col_d = col_ok ? col_q : ColW'(COLS - 1);
            go_fin    = 1'b1;
          end
          MODE_RD: begin
            ram_re_o  = row_ok && col_ok;
            rd_pend_d = row_ok && col_ok;
            state_d   = S_RDATA;
          end
          default: begin
            go_fin = 1'b1;
          end
        endcase
      end
      S_RDATA: begin
        if (rd_pend_q) begin
          fin_char = ram_rdata_i[7:0];
          fin_attr = ram_rdata_i[15:8];
        end
        rd_pend_d = 1'b0;
        go_fin    = 1'b1;
      end
      S_SCROLL: begin
        // read one row below, write it back in the next cycle
        if (cnt_q != AW'(NMove)) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = cnt_q + AW'(COLS);
          cnt_d       = cnt_q + 1'b1;
          rd_pend_d   = 1'b1;
        end else begin
          rd_pend_d = 1'b0;
        end
        if (rd_pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = cnt_q - 1'b1;
          ram_wdata_o = ram_rdata_i;
        end
        if (cnt_q == AW'(NMove) && rd_pend_q) begin
          cnt_d      = AW'(NMove);
          clr_last_d = AW'(NCell - 1);
          state_d    = S_CLEAR;
        end
      end
      S_CLEAR: begin
        ram_we_o = 1'b1;
        if (cnt_q == clr_last_q) begin
          if (mode_q == MODE_PUT) begin
            state_d = S_EXEC;
          end else begin
            go_fin = 1'b1;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_HOLD: begin
        fin_char = hold_char_q;
        fin_attr = hold_attr_q;
        go_fin   = 1'b1;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase

    if (go_fin) begin
      if (out_free_i) begin
        state_d = S_IDLE;
      end else begin
        hold_char_d = fin_char;
        hold_attr_d = fin_attr;
        state_d     = S_HOLD;
      end
    end
  end

  always_comb begin
    res_o.vld       = go_fin && out_free_i;
    res_o.col       = cur_col_d;
    res_o.row       = RowW'(cur_row_d);
    res_o.offset    = OffW'(int'(cur_row_d) * COLS + int'(cur_col_d));
    res_o.char_code = fin_char;
    res_o.attr      = fin_attr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      cnt_q      <= '0;
      clr_last_q <= '0;
      rd_pend_q  <= 1'b0;
      mode_q     <= MODE_PUT;
    end else begin
      state_q    <= state_d;
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      cnt_q      <= cnt_d;
      clr_last_q <= clr_last_d;
      rd_pend_q  <= rd_pend_d;
      mode_q     <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q      <= char_d;
    row_q       <= row_d;
    col_q       <= col_d;
    hold_char_q <= hold_char_d;
    hold_attr_q <= hold_attr_d;
  end

endmodule

// ----- design/text_console_cursor_engine_top.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Text console with cursor over a character and attribute cell store.
// ----------------------------------------------------------------------------
// After reset the block walks the whole cell store once to zero it, with
// in_ready_o low; text color writes are taken during that time. The cell
// store is a single memory with one write and one read port. Put char, set
// cursor and the unused modes give their result from the execute state; read
// cell issues the read there and gives the result from the read data state. A
// put char with a scroll pending first moves COLS*(ROWS-1) cells at one per
// cycle and clears the bottom row. Clear line clears the COLS cells of its
// row, clear screen all COLS*ROWS cells. One request is in work at a time;
// the next one is accepted while the previous result still waits in the
// output register.
module text_console_cursor_engine_top import tcce_pkg::*; #(
  parameter int COLS     = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [ByteW-1:0] text_color_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ModeW-1:0] mode_i,
  input  logic [ByteW-1:0] char_code_i,
  input  logic [RowW-1:0]  row_i,
  input  logic [ColW-1:0]  column_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ColW-1:0]  cursor_col_o,
  output logic [RowW-1:0]  cursor_row_o,
  output logic [OffW-1:0]  cursor_offset_o,
  output logic [ByteW-1:0] cell_char_o,
  output logic [ByteW-1:0] cell_attr_o
);

  localparam int NCell = COLS * ROWS;
  localparam int AW    = $clog2(NCell);

  logic [ByteW-1:0] color_q, color_d;
  logic             out_valid_q, out_valid_d;
  tcce_res_t        out_q, out_d;
  tcce_res_t        res;
  logic             out_free;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  tcce_core #(
    .COLS     (COLS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .row_i        (row_i),
    .column_i     (column_i),
    .text_color_i (color_q),
    .out_free_i   (out_free),
    .res_o        (res),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  tcce_ram #(
    .WIDTH (CellW),
    .DEPTH (NCell)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    color_d     = color_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (cfg_valid_i) begin
      color_d = text_color_i;
    end
    if (res.vld) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= TEXT_COLOR_RST;
      out_valid_q <= 1'b0;
    end else begin
      color_q     <= color_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o     = out_valid_q;
  assign cursor_col_o    = out_q.col;
  assign cursor_row_o    = out_q.row;
  assign cursor_offset_o = out_q.offset;
  assign cell_char_o     = out_q.char_code;
  assign cell_attr_o     = out_q.attr;

endmodule

// ----- design/tcce_checker.sv -----
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the text console cursor engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_checker import tcce_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ColW-1:0]  cursor_col_o,
  input logic [RowW-1:0]  cursor_row_o,
  input logic [OffW-1:0]  cursor_offset_o,
  input logic [ByteW-1:0] cell_char_o,
  input logic [ByteW-1:0] cell_attr_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cursor_col_o) &&
      $stable(cursor_row_o) && $stable(cursor_offset_o) &&
      $stable(cell_char_o) && $stable(cell_attr_o))
    else $error("result changed while stalled");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(cursor_col_o) < COLS)
    else $error("cursor column out of range");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ROWS > 31) ||
      (cursor_offset_o == OffW'(int'(cursor_row_o) * COLS + int'(cursor_col_o))))
    else $error("cursor offset does not match row and column");

  // no request taken and no result shown right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !in_ready_o && !out_valid_o)
    else $error("activity right after reset");

endmodule

bind text_console_cursor_engine_top tcce_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_checker (.*);
